@@ rtl/hbef_pkg.sv @@
`timescale 1ns / 1ps

package hbef_pkg;

  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned MAG_W       = COORD_WIDTH + 1;
  localparam int unsigned SQ_W        = 2 * COORD_WIDTH + 2;
  localparam int unsigned ROOT_W      = COORD_WIDTH + 1;
  localparam int unsigned ERR_W       = (ROOT_W > 32) ? ROOT_W : 32;
  localparam int unsigned KE_W        = 33 + ERR_W;
  localparam int unsigned NUM_W       = KE_W + MAG_W;
  localparam int unsigned PROD_W      = (NUM_W > 2 * ERR_W + 32) ? NUM_W : 2 * ERR_W + 32;
  localparam int unsigned DEN_W       = ROOT_W + 16;
  localparam int unsigned SREM_W      = ROOT_W + 3;
  localparam int unsigned CNT_W       = $clog2(NUM_W);
  localparam int unsigned FORCE_W     = 48;
  localparam int unsigned ENERGY_W    = 48;
  localparam int unsigned SUM_W       = 63;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] first_z;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
    logic signed [COORD_WIDTH-1:0] second_z;
    logic [31:0]                   spring_k;
    logic [31:0]                   rest_length;
    logic                          first_selected;
    logic                          second_selected;
    logic                          last_bond;
  } in_t;

  typedef struct packed {
    logic signed [FORCE_W-1:0] force_x;
    logic signed [FORCE_W-1:0] force_y;
    logic signed [FORCE_W-1:0] force_z;
    logic                      apply_first;
    logic                      apply_second;
    logic [ENERGY_W-1:0]       bond_energy;
    logic [SUM_W-1:0]          total_energy;
    logic                      sum_done;
  } out_t;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] dmag;
    logic [2:0]            dneg;
    logic [31:0]           spring_k;
    logic [31:0]           rest_length;
    logic                  counted;
    logic                  apply_first;
    logic                  apply_second;
    logic                  last_bond;
  } job_t;

  typedef enum logic [3:0] {
    BS_IDLE,
    BS_SQ,
    BS_ROOT,
    BS_ERR,
    BS_E2,
    BS_EK,
    BS_KS,
    BS_KE,
    BS_NUM,
    BS_DIV,
    BS_DONE
  } back_state_e;

endpackage

@@ rtl/hbef_queue.sv @@
`timescale 1ns / 1ps

module hbef_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

@@ rtl/hbef_front.sv @@
`timescale 1ns / 1ps

module hbef_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_data_i,
  input  hbef_pkg::in_t       in_i,
  output hbef_pkg::job_t      job_o
);

  logic                               use_sel_q;
  logic signed [hbef_pkg::MAG_W-1:0]  dlt [3];
  logic signed [hbef_pkg::COORD_WIDTH-1:0] a_c [3];
  logic signed [hbef_pkg::COORD_WIDTH-1:0] b_c [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_sel_q <= 1'b0;
    end else if (cfg_we_i) begin
      use_sel_q <= cfg_data_i;
    end
  end

  assign a_c[0] = in_i.first_x;
  assign a_c[1] = in_i.first_y;
  assign a_c[2] = in_i.first_z;
  assign b_c[0] = in_i.second_x;
  assign b_c[1] = in_i.second_y;
  assign b_c[2] = in_i.second_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dlt[i] = hbef_pkg::MAG_W'(a_c[i]) - hbef_pkg::MAG_W'(b_c[i]);
      job_o.dneg[i] = dlt[i][hbef_pkg::MAG_W-1];
      job_o.dmag[i] = job_o.dneg[i] ? hbef_pkg::MAG_W'(-dlt[i]) : hbef_pkg::MAG_W'(dlt[i]);
    end
    job_o.spring_k     = in_i.spring_k;
    job_o.rest_length  = in_i.rest_length;
    job_o.counted      = !use_sel_q || in_i.first_selected || in_i.second_selected;
    job_o.apply_first  = !use_sel_q || in_i.first_selected;
    job_o.apply_second = !use_sel_q || in_i.second_selected;
    job_o.last_bond    = in_i.last_bond;
  end

endmodule

@@ rtl/hbef_back.sv @@
`timescale 1ns / 1ps

module hbef_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_empty_i,
  input  hbef_pkg::job_t      job_i,
  output logic                job_pop_o,
  output logic                empty,
  input  logic                pop,
  output hbef_pkg::out_t      out_o
);

  localparam int unsigned PW = hbef_pkg::PROD_W;
  localparam int unsigned EW = hbef_pkg::ERR_W;
  localparam int unsigned FW = hbef_pkg::FORCE_W;

  hbef_pkg::back_state_e state_q, state_d;
  hbef_pkg::job_t        job_q, job_d;
  logic [1:0]            comp_q, comp_d, comp_nx;
  logic [PW-1:0]         mul_a_q, mul_a_d, acc_q, acc_d, acc_step;
  logic [EW-1:0]         mul_b_q, mul_b_d;
  logic [hbef_pkg::SQ_W-1:0]   sq_q, sq_d;
  logic [hbef_pkg::SREM_W-1:0] srem_q, srem_d, s_in, s_trial;
  logic [hbef_pkg::ROOT_W-1:0] root_q, root_d;
  logic [hbef_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [hbef_pkg::KE_W-1:0]   ke_q, ke_d;
  logic [hbef_pkg::DEN_W-1:0]  drem_q, drem_d;
  logic [hbef_pkg::DEN_W:0]    d_in, d_den;
  logic [FW-1:0]         quo_q, quo_d;
  logic                  ovf_q, ovf_d, d_ge;
  logic [hbef_pkg::ENERGY_W-1:0] energy_q, energy_d;
  logic [2:0][FW-1:0]    force_q, force_d;
  logic [hbef_pkg::SUM_W-1:0] sum_q, sum_d;
  logic [hbef_pkg::SUM_W:0]   tot_w;
  logic [hbef_pkg::SUM_W-1:0] tot_sat;
  hbef_pkg::out_t        out_q, out_d;
  logic                  out_valid_q, out_valid_d;
  logic                  mul_done, eneg;
  logic [EW-1:0]         d_ext, r0_ext, emag;
  logic [FW-1:0]         f_mag, f_lim, f_val;
  logic                  f_neg;

  assign empty = !out_valid_q;
  assign out_o = out_q;

  assign mul_done = (mul_b_q == '0);
  assign acc_step = acc_q + (mul_b_q[0] ? mul_a_q : '0);
  assign comp_nx  = comp_q + 2'd1;

  assign d_ext  = EW'(root_q);
  assign r0_ext = EW'(job_q.rest_length);
  assign eneg   = d_ext < r0_ext;
  assign emag   = eneg ? r0_ext - d_ext : d_ext - r0_ext;

  assign s_in    = {srem_q[hbef_pkg::SREM_W-3:0], sq_q[hbef_pkg::SQ_W-1 -: 2]};
  assign s_trial = hbef_pkg::SREM_W'({root_q, 2'b01});

  assign d_in  = {drem_q, acc_q[hbef_pkg::NUM_W-1]};
  assign d_den = (hbef_pkg::DEN_W + 1)'({root_q, 16'h0000});
  assign d_ge  = d_in >= d_den;

  always_comb begin
    f_neg = eneg != job_q.dneg[comp_q];
    f_lim = f_neg ? {1'b1, {(FW-1){1'b0}}} : {1'b0, {(FW-1){1'b1}}};
    f_mag = (ovf_q || quo_q[FW-1] || ({quo_q[FW-2:0], d_ge} > f_lim)) ? f_lim
          : {quo_q[FW-2:0], d_ge};
    f_val = f_neg ? -f_mag : f_mag;
  end

  assign tot_w   = {1'b0, sum_q} + (hbef_pkg::SUM_W + 1)'(energy_q);
  assign tot_sat = tot_w[hbef_pkg::SUM_W] ? '1 : tot_w[hbef_pkg::SUM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hbef_pkg::BS_IDLE;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      sum_q       <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    comp_q   <= comp_d;
    mul_a_q  <= mul_a_d;
    mul_b_q  <= mul_b_d;
    acc_q    <= acc_d;
    sq_q     <= sq_d;
    srem_q   <= srem_d;
    root_q   <= root_d;
    cnt_q    <= cnt_d;
    ke_q     <= ke_d;
    drem_q   <= drem_d;
    quo_q    <= quo_d;
    ovf_q    <= ovf_d;
    energy_q <= energy_d;
    force_q  <= force_d;
    out_q    <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    comp_d      = comp_q;
    mul_a_d     = mul_a_q;
    mul_b_d     = mul_b_q;
    acc_d       = acc_q;
    sq_d        = sq_q;
    srem_d      = srem_q;
    root_d      = root_q;
    cnt_d       = cnt_q;
    ke_d        = ke_q;
    drem_d      = drem_q;
    quo_d       = quo_q;
    ovf_d       = ovf_q;
    energy_d    = energy_q;
    force_d     = force_q;
    out_d       = out_q;
    sum_d       = sum_q;
    job_pop_o   = 1'b0;
    out_valid_d = out_valid_q && !pop;

    unique case (state_q)
      hbef_pkg::BS_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          comp_d    = 2'd0;
          acc_d     = '0;
          mul_a_d   = PW'(job_i.dmag[0]);
          mul_b_d   = EW'(job_i.dmag[0]);
          state_d   = hbef_pkg::BS_SQ;
        end
      end
      hbef_pkg::BS_SQ: begin
        if (!mul_done) begin
          acc_d   = acc_step;
          mul_a_d = mul_a_q << 1;
          mul_b_d = mul_b_q >> 1;
        end else if (comp_q != 2'd2) begin
          comp_d  = comp_nx;
          mul_a_d = PW'(job_q.dmag[comp_nx]);
          mul_b_d = EW'(job_q.dmag[comp_nx]);
        end else begin
          sq_d    = acc_q[hbef_pkg::SQ_W-1:0];
          srem_d  = '0;
          root_d  = '0;
          cnt_d   = '0;
          state_d = hbef_pkg::BS_ROOT;
        end
      end
      hbef_pkg::BS_ROOT: begin
        sq_d = sq_q << 2;
        if (s_in >= s_trial) begin
          srem_d = s_in - s_trial;
          root_d = {root_q[hbef_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          srem_d = s_in;
          root_d = {root_q[hbef_pkg::ROOT_W-2:0], 1'b0};
        end
        cnt_d = cnt_q + hbef_pkg::CNT_W'(1);
        if (cnt_q == hbef_pkg::CNT_W'(hbef_pkg::ROOT_W - 1)) begin
          state_d = hbef_pkg::BS_ERR;
        end
      end
      hbef_pkg::BS_ERR: begin
        if (job_q.counted) begin
          acc_d   = '0;
          mul_a_d = PW'(emag);
          mul_b_d = emag;
          state_d = hbef_pkg::BS_E2;
        end else begin
          energy_d = '0;
          state_d  = hbef_pkg::BS_KS;
        end
      end
      hbef_pkg::BS_E2: begin
        if (!mul_done) begin
          acc_d   = acc_step;
          mul_a_d = mul_a_q << 1;
          mul_b_d = mul_b_q >> 1;
        end else begin
          mul_a_d = acc_q;
          mul_b_d = EW'(job_q.spring_k);
          acc_d   = '0;
          state_d = hbef_pkg::BS_EK;
        end
      end
      hbef_pkg::BS_EK: begin
        if (!mul_done) begin
          acc_d   = acc_step;
          mul_a_d = mul_a_q << 1;
          mul_b_d = mul_b_q >> 1;
        end else begin
          energy_d = (|acc_q[PW-1:80]) ? '1 : acc_q[79:32];
          state_d  = hbef_pkg::BS_KS;
        end
      end
      hbef_pkg::BS_KS: begin
        if (root_q == '0) begin
          force_d = '0;
          state_d = hbef_pkg::BS_DONE;
        end else begin
          acc_d   = '0;
          mul_a_d = PW'({job_q.spring_k, 1'b0});
          mul_b_d = emag;
          state_d = hbef_pkg::BS_KE;
        end
      end
      hbef_pkg::BS_KE: begin
        if (!mul_done) begin
          acc_d   = acc_step;
          mul_a_d = mul_a_q << 1;
          mul_b_d = mul_b_q >> 1;
        end else begin
          ke_d    = acc_q[hbef_pkg::KE_W-1:0];
          mul_a_d = PW'(acc_q[hbef_pkg::KE_W-1:0]);
          mul_b_d = EW'(job_q.dmag[0]);
          acc_d   = '0;
          comp_d  = 2'd0;
          state_d = hbef_pkg::BS_NUM;
        end
      end
      hbef_pkg::BS_NUM: begin
        if (!mul_done) begin
          acc_d   = acc_step;
          mul_a_d = mul_a_q << 1;
          mul_b_d = mul_b_q >> 1;
        end else begin
          drem_d  = '0;
          quo_d   = '0;
          ovf_d   = 1'b0;
          cnt_d   = '0;
          state_d = hbef_pkg::BS_DIV;
        end
      end
      hbef_pkg::BS_DIV: begin
        acc_d  = acc_q << 1;
        drem_d = d_ge ? hbef_pkg::DEN_W'(d_in - d_den) : hbef_pkg::DEN_W'(d_in);
        quo_d  = {quo_q[FW-2:0], d_ge};
        ovf_d  = ovf_q || quo_q[FW-1];
        cnt_d  = cnt_q + hbef_pkg::CNT_W'(1);
        if (cnt_q == hbef_pkg::CNT_W'(hbef_pkg::NUM_W - 1)) begin
          force_d[comp_q] = f_val;
          if (comp_q == 2'd2) begin
            state_d = hbef_pkg::BS_DONE;
          end else begin
            comp_d  = comp_nx;
            mul_a_d = PW'(ke_q);
            mul_b_d = EW'(job_q.dmag[comp_nx]);
            acc_d   = '0;
            state_d = hbef_pkg::BS_NUM;
          end
        end
      end
      hbef_pkg::BS_DONE: begin
        if (!out_valid_q || pop) begin
          out_d.force_x      = force_q[0];
          out_d.force_y      = force_q[1];
          out_d.force_z      = force_q[2];
          out_d.apply_first  = job_q.apply_first;
          out_d.apply_second = job_q.apply_second;
          out_d.bond_energy  = energy_q;
          out_d.total_energy = tot_sat;
          out_d.sum_done     = job_q.last_bond;
          sum_d              = job_q.last_bond ? '0 : tot_sat;
          out_valid_d        = 1'b1;
          state_d            = hbef_pkg::BS_IDLE;
        end
      end
      default: begin
        state_d = hbef_pkg::BS_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/harmonic_bond_energy_force.sv @@
// Timing: set by the shared bit-serial multiplier (stops when its multiplier runs out, so
// short operands finish sooner), the one-pair-a-cycle root and the one-bit-a-cycle
// divider, which runs once per force component.
// Flow: the back end works on one bond per pass and takes a new one only after the last
// is out; the two-entry queue takes bonds meanwhile, and a result not yet popped holds
// the back end. Reset: rst_ni clears the queue, sequencer, energy sum and the selection
// mode.
`timescale 1ns / 1ps

module harmonic_bond_energy_force #(
  parameter int unsigned QUEUE_DEPTH = hbef_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_data_i,
  input  logic           push,
  output logic           full,
  input  hbef_pkg::in_t  in_i,
  output logic           empty,
  input  logic           pop,
  output hbef_pkg::out_t out_o
);

  hbef_pkg::job_t front_job, back_job;
  logic           q_empty, q_pop;

  hbef_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .job_o      (front_job)
  );

  hbef_queue #(
    .WIDTH ($bits(hbef_pkg::job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_job),
    .full_o  (full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (back_job)
  );

  hbef_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (q_empty),
    .job_i       (back_job),
    .job_pop_o   (q_pop),
    .empty       (empty),
    .pop         (pop),
    .out_o       (out_o)
  );

endmodule

@@ test/harmonic_bond_energy_force_tb.sv @@
`timescale 1ns / 1ps

module harmonic_bond_energy_force_tb;

  localparam int unsigned STALL_LIMIT = 20000;
  localparam logic [47:0] FORCE_POS_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] ENERGY_MAX    = 48'hFFFF_FFFF_FFFF;
  localparam logic [62:0] SUM_MAX       = {63{1'b1}};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_data_i = 1'b0;
  logic push = 1'b0;
  logic full;
  hbef_pkg::in_t  in_i = '0;
  logic empty;
  logic pop = 1'b0;
  hbef_pkg::out_t out_o;

  harmonic_bond_energy_force dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i,
    .push, .full, .in_i, .empty, .pop, .out_o
  );

  hbef_pkg::out_t expected_bonds[$];
  logic [62:0] energy_acc = '0;
  logic        sel_mode = 1'b0;
  bit          idle_on = 1'b0;
  int unsigned hold_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned bonds_sent = 0;
  int unsigned bonds_checked = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic hbef_pkg::out_t bond_result(hbef_pkg::in_t b);
    hbef_pkg::out_t r;
    longint      dlt[3];
    logic [63:0] dm[3];
    logic [127:0] sq, c2, prod;
    logic [63:0] d, c, emag, r0, lim, mag;
    logic [191:0] num, den, q;
    logic        eneg, counted, neg;
    logic [47:0] be;
    logic [63:0] total;
    dlt[0] = longint'(b.first_x) - longint'(b.second_x);
    dlt[1] = longint'(b.first_y) - longint'(b.second_y);
    dlt[2] = longint'(b.first_z) - longint'(b.second_z);
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      dm[i] = dlt[i] < 0 ? 64'(-dlt[i]) : 64'(dlt[i]);
      sq += {64'b0, dm[i]} * {64'b0, dm[i]};
    end
    d = '0;
    for (int i = 63; i >= 0; i--) begin
      c = d | (64'd1 << i);
      c2 = {64'b0, c} * {64'b0, c};
      if (c2 <= sq) d = c;
    end
    r0 = {32'b0, b.rest_length};
    eneg = d < r0;
    emag = eneg ? r0 - d : d - r0;
    counted = !sel_mode || b.first_selected || b.second_selected;
    be = '0;
    if (counted) begin
      prod = {64'b0, emag} * {64'b0, emag} * {96'b0, b.spring_k};
      be = (prod[127:80] != 0) ? ENERGY_MAX : prod[79:32];
    end
    for (int i = 0; i < 3; i++) begin
      logic [47:0] f;
      f = '0;
      if (d != 0) begin
        num = {159'b0, b.spring_k, 1'b0} * {128'b0, emag} * {128'b0, dm[i]};
        den = {128'b0, d} << 16;
        q = num / den;
        neg = eneg != (dlt[i] < 0);
        lim = neg ? {16'b0, FORCE_POS_MAX} + 64'd1 : {16'b0, FORCE_POS_MAX};
        mag = (q > {128'b0, lim}) ? lim : q[63:0];
        f = neg ? 48'(-mag) : mag[47:0];
      end
      if (i == 0) r.force_x = f;
      else if (i == 1) r.force_y = f;
      else r.force_z = f;
    end
    total = {1'b0, energy_acc} + {16'b0, be};
    if (total > {1'b0, SUM_MAX}) total = {1'b0, SUM_MAX};
    energy_acc = b.last_bond ? '0 : total[62:0];
    r.apply_first = !sel_mode || b.first_selected;
    r.apply_second = !sel_mode || b.second_selected;
    r.bond_energy = be;
    r.total_energy = total[62:0];
    r.sum_done = b.last_bond;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got %h, expected %h", field, got, want);
    mismatches++;
  endtask

  task automatic check_bond(hbef_pkg::out_t got);
    hbef_pkg::out_t want;
    if (expected_bonds.size() == 0) begin
      report_mismatch("unexpected transfer", 64'(got.total_energy), 64'd0);
      return;
    end
    want = expected_bonds.pop_front();
    bonds_checked++;
    if (got.force_x !== want.force_x)
      report_mismatch("force_x", 64'(got.force_x), 64'(want.force_x));
    if (got.force_y !== want.force_y)
      report_mismatch("force_y", 64'(got.force_y), 64'(want.force_y));
    if (got.force_z !== want.force_z)
      report_mismatch("force_z", 64'(got.force_z), 64'(want.force_z));
    if (got.apply_first !== want.apply_first)
      report_mismatch("apply_first", 64'(got.apply_first), 64'(want.apply_first));
    if (got.apply_second !== want.apply_second)
      report_mismatch("apply_second", 64'(got.apply_second), 64'(want.apply_second));
    if (got.bond_energy !== want.bond_energy)
      report_mismatch("bond_energy", 64'(got.bond_energy), 64'(want.bond_energy));
    if (got.total_energy !== want.total_energy)
      report_mismatch("total_energy", 64'(got.total_energy), 64'(want.total_energy));
    if (got.sum_done !== want.sum_done)
      report_mismatch("sum_done", 64'(got.sum_done), 64'(want.sum_done));
  endtask

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        pop <= 1'b0;
      end else begin
        pop <= !(idle_on && $urandom_range(99) < 9);
      end
      @(posedge clk_i);
      if (pop && !empty) check_bond(out_o);
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic send_bond(hbef_pkg::in_t b);
    @(negedge clk_i);
    while (idle_on && $urandom_range(99) < 9) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    in_i <= b;
    do @(posedge clk_i); while (full);
    expected_bonds.insert(expected_bonds.size(), bond_result(b));
    bonds_sent++;
  endtask

  task automatic drain;
    @(negedge clk_i);
    push <= 1'b0;
    while (expected_bonds.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_selection(logic v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sel_mode = v;
  endtask

  function automatic logic [31:0] rand_bits();
    return $urandom() >> $urandom_range(31);
  endfunction

  function automatic hbef_pkg::in_t random_bond();
    hbef_pkg::in_t b;
    int  base;
    b = '0;
    if ($urandom_range(99) < 70) begin
      base = $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
      b.first_x = base + $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
      b.first_y = base + $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
      b.first_z = base + $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
      b.second_x = base;
      b.second_y = base - $urandom_range(0, 32'h3_FFFF);
      b.second_z = base + $urandom_range(0, 32'h3_FFFF);
      b.spring_k = rand_bits();
      b.rest_length = $urandom_range(0, 32'h6_FFFF);
    end else begin
      b.first_x = $urandom();
      b.first_y = $urandom();
      b.first_z = $urandom();
      b.second_x = $urandom();
      b.second_y = $urandom();
      b.second_z = $urandom();
      b.spring_k = $urandom();
      b.rest_length = $urandom();
    end
    b.first_selected = 1'($urandom_range(1));
    b.second_selected = 1'($urandom_range(1));
    b.last_bond = $urandom_range(7) == 0;
    return b;
  endfunction

  task automatic test_directed;
    hbef_pkg::in_t b;
    b = '0;
    b.spring_k = 32'h0001_0000;
    b.rest_length = 32'h0001_0000;
    send_bond(b);
    b.first_x = 32'h0001_0000;
    send_bond(b);
    b.first_x = 32'h7FFF_FFFF; b.first_y = 32'h7FFF_FFFF; b.first_z = 32'h7FFF_FFFF;
    b.second_x = 32'h8000_0000; b.second_y = 32'h8000_0000; b.second_z = 32'h8000_0000;
    b.spring_k = 32'hFFFF_FFFF;
    b.rest_length = 32'h0;
    send_bond(b);
    b.rest_length = 32'hFFFF_FFFF;
    b.first_selected = 1'b1; b.second_selected = 1'b1;
    send_bond(b);
    b.spring_k = 32'h0;
    b.last_bond = 1'b1;
    send_bond(b);
    b = '0;
    b.first_x = 32'h0000_0001; b.second_y = 32'h0000_0001;
    b.spring_k = 32'hFFFF_FFFF; b.rest_length = 32'hFFFF_FFFF;
    send_bond(b);
    b.first_x = 32'h8000_0000; b.second_x = 32'h7FFF_FFFF;
    b.first_y = 32'h0; b.second_y = 32'h0;
    b.rest_length = 32'h0;
    send_bond(b);
    b.first_x = 32'h0003_0000; b.second_x = 32'h0;
    b.first_z = 32'hFFFC_0000;
    b.rest_length = 32'h0005_0000;
    b.last_bond = 1'b1;
    send_bond(b);
  endtask

  task automatic test_selection;
    hbef_pkg::in_t b;
    write_selection(1'b1);
    for (int i = 0; i < 4; i++) begin
      b = random_bond();
      b.first_selected = i[0];
      b.second_selected = i[1];
      b.last_bond = i == 3;
      send_bond(b);
    end
  endtask

  task automatic test_random_bonds(int unsigned count, bit with_idle);
    idle_on = with_idle;
    for (int unsigned i = 0; i < count; i++) send_bond(random_bond());
  endtask

  task automatic test_backpressure;
    @(negedge clk_i);
    push <= 1'b0;
    hold_cycles = 3000;
    for (int i = 0; i < 6; i++) send_bond(random_bond());
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_selection();
    test_random_bonds(200, 1'b1);
    write_selection(1'b0);
    test_random_bonds(150, 1'b0);
    test_backpressure();
    test_random_bonds(250, 1'b1);
    write_selection(1'b1);
    test_random_bonds(230, 1'b1);
    drain();
    repeat (600) @(negedge clk_i);
    $display("covered %0d bonds, %0d results checked, both selection settings,",
             bonds_sent, bonds_checked);
    $display("zero distance, saturating extremes, sum clears and a long output stall");
    if (mismatches == 0 && expected_bonds.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ harmonic_bond_energy_force.f @@
rtl/hbef_pkg.sv
rtl/hbef_queue.sv
rtl/hbef_front.sv
rtl/hbef_back.sv
rtl/harmonic_bond_energy_force.sv
test/harmonic_bond_energy_force_tb.sv
